>>> src/ipt_pkg.sv
// ----------------------------------------------------------------------------
// Isometric point transform package
// Shared types, register indexes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
package ipt_pkg;

  localparam int CoordW = 16;
  localparam int CoefW  = 16;
  localparam int OutW   = 24;
  localparam int IdxW   = 3;

  // Register stages from the input beat up to and including the output register.
  localparam int NStg   = 5;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [OutW-1:0]   pix_t;

  typedef enum logic [IdxW-1:0] {
    REG_COS_FIRST   = 3'd0,
    REG_SIN_FIRST   = 3'd1,
    REG_COS_SECOND  = 3'd2,
    REG_SIN_SECOND  = 3'd3,
    REG_HEIGHT_GAIN = 3'd4,
    REG_CENTRE_X    = 3'd5,
    REG_CENTRE_Y    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoefW-1:0] cos_first;
    logic signed [CoefW-1:0] sin_first;
    logic signed [CoefW-1:0] cos_second;
    logic signed [CoefW-1:0] sin_second;
    logic signed [CoefW-1:0] height_gain;
    logic signed [CoefW-1:0] centre_x;
    logic signed [CoefW-1:0] centre_y;
  } cfg_t;

  localparam coef_t RstCosFirst  = 16'sd11585;
  localparam coef_t RstSinFirst  = 16'sd11585;
  localparam coef_t RstCosSecond = 16'sd8192;
  localparam coef_t RstSinSecond = 16'sd14189;
  localparam coef_t RstGain      = 16'sd256;
  localparam coef_t RstCentreX   = 16'sd0;
  localparam coef_t RstCentreY   = 16'sd0;

  function automatic coord_t sat16(input logic signed [24:0] v);
    coord_t r;
    if (v > 25'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -25'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic pix_t sat24(input logic signed [31:0] v);
    pix_t r;
    if (v > 32'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

>>> src/ipt_in_if.sv
// ----------------------------------------------------------------------------
// Point input channel
// Valid/ready channel that carries one map point per beat.
// ----------------------------------------------------------------------------
interface ipt_in_if
  import ipt_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t x_in;
  coord_t y_in;
  coord_t z_in;
  logic   last_point;

  modport source (output valid, output x_in, output y_in, output z_in,
                  output last_point, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in,
                  input last_point, output ready);
endinterface

>>> src/ipt_out_if.sv
// ----------------------------------------------------------------------------
// Projected point output channel
// Valid/ready channel that carries one projected point per beat.
// ----------------------------------------------------------------------------
interface ipt_out_if
  import ipt_pkg::*;
;
  logic valid;
  logic ready;
  pix_t x_out;
  pix_t y_out;
  pix_t z_out;
  logic last_out;

  modport source (output valid, output x_out, output y_out, output z_out,
                  output last_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out,
                  input last_out, output ready);
endinterface

>>> src/isometric_point_transform.sv
// ----------------------------------------------------------------------------
// Isometric point transform
// Height scaling, z then y rotation and screen offset for one map point.
// ----------------------------------------------------------------------------
// The block takes one point per clock while no output stall holds it back;
// a stall on the output side backs up stage by stage, so empty stages
// still fill while the result register waits. The five register stages are:
// first-rotation and height products, rotation sums with height rounding,
// second-rotation products, second-rotation sums with the x offset and rounding
// bias, and finally the shift and saturation into the output register. Each
// stage holds at most one multiplier per product path. Configuration writes
// take effect on the next cycle and should be made while the pipeline is empty.
module isometric_point_transform
  import ipt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  ipt_in_if.sink          in_ch,
  ipt_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [15:0]     cfg_wdata
);

  cfg_t cfg;

  ipt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Per-stage valid bits and load enables.
  logic [NStg-1:0] v_r;
  logic [NStg-1:0] v_nxt;
  logic [NStg-1:0] ld;
  logic [NStg-1:0] last_r;

  always_comb begin
    ld[NStg-1] = !v_r[NStg-1] || out_ch.ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    v_nxt = v_r;
    v_nxt[0] = ld[0] ? in_ch.valid : v_r[0];
    for (int k = 1; k < NStg; k++) begin
      if (ld[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = ld[0];

  // The last-point flag travels alongside the data of each stage.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      last_r[0] <= in_ch.last_point;
    end
    for (int k = 1; k < NStg; k++) begin
      if (ld[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // Stage 0: first rotation and height products.
  logic signed [31:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r, p_zg_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p_xc_r    <= 32'(in_ch.x_in) * 32'(cfg.cos_first);
      p_ys_r    <= 32'(in_ch.y_in) * 32'(cfg.sin_first);
      p_xs_r    <= 32'(in_ch.x_in) * 32'(cfg.sin_first);
      p_yc_r    <= 32'(in_ch.y_in) * 32'(cfg.cos_first);
      p_zg_r    <= 32'(in_ch.z_in) * 32'(cfg.height_gain);
    end
  end

  // Stage 1: rotated x/y in Q.14 and the rounded, saturated height.
  logic signed [32:0] x1_r, y1_r;
  coord_t             z1_r;
  logic signed [32:0] zr;
  logic signed [24:0] zs;

  assign zr = 33'(p_zg_r) + 33'sd128;
  assign zs = 25'(zr >>> 8);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      x1_r      <= 33'(p_xc_r) - 33'(p_ys_r);
      y1_r      <= 33'(p_xs_r) + 33'(p_yc_r);
      z1_r      <= sat16(zs);
    end
  end

  // Stage 2: second rotation products; y gets its offset and rounding bias.
  logic signed [48:0] m_xcs_r, m_xss_r;
  logic signed [31:0] m_zss_r, m_zcs_r;
  logic signed [34:0] yb2_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      m_xcs_r   <= 49'(x1_r) * 49'(cfg.cos_second);
      m_xss_r   <= 49'(x1_r) * 49'(cfg.sin_second);
      m_zss_r   <= 32'(z1_r) * 32'(cfg.sin_second);
      m_zcs_r   <= 32'(z1_r) * 32'(cfg.cos_second);
      yb2_r     <= 35'(y1_r) + (35'(cfg.centre_y) <<< 14) + 35'sd32;
    end
  end

  // Stage 3: second rotation sums in Q.28 with the half-LSB bias folded in.
  logic signed [49:0] x2b_r, z2b_r;
  logic signed [34:0] yb3_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      x2b_r     <= 50'(m_xcs_r) - (50'(m_zss_r) <<< 14)
                   + (50'(cfg.centre_x) <<< 28) + 50'sd524288;
      z2b_r     <= 50'(m_xss_r) + (50'(m_zcs_r) <<< 14) + 50'sd524288;
      yb3_r     <= yb2_r;
    end
  end

  // Stage 4: drop fraction bits down to Q16.8 and saturate.
  pix_t xo_r, yo_r, zo_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      xo_r      <= sat24(32'(x2b_r >>> 20));
      yo_r      <= sat24(32'(yb3_r >>> 6));
      zo_r      <= sat24(32'(z2b_r >>> 20));
    end
  end

  assign out_ch.valid    = v_r[NStg-1];
  assign out_ch.x_out    = xo_r;
  assign out_ch.y_out    = yo_r;
  assign out_ch.z_out    = zo_r;
  assign out_ch.last_out = last_r[NStg-1];

  // Items in flight, tracked from the channel beats.
  logic [2:0] occ_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + 3'(in_beat) - 3'(out_beat);
    end
  end

  a_occ_matches_valids: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == 3'($countones(v_r)))
    else $error("pipeline valid bits disagree with beats in flight");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled while a pipeline stage was empty");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule

>>> src/ipt_cfg_regs.sv
// ----------------------------------------------------------------------------
// Isometric transform configuration registers
// Seven 16-bit coefficient and offset registers behind a simple write port.
// ----------------------------------------------------------------------------
module ipt_cfg_regs
  import ipt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [15:0]     cfg_wdata,
  output cfg_t            cfg
);

  cfg_t regs_r;
  cfg_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COS_FIRST:   regs_nxt.cos_first   = cfg_wdata;
        REG_SIN_FIRST:   regs_nxt.sin_first   = cfg_wdata;
        REG_COS_SECOND:  regs_nxt.cos_second  = cfg_wdata;
        REG_SIN_SECOND:  regs_nxt.sin_second  = cfg_wdata;
        REG_HEIGHT_GAIN: regs_nxt.height_gain = cfg_wdata;
        REG_CENTRE_X:    regs_nxt.centre_x    = cfg_wdata;
        REG_CENTRE_Y:    regs_nxt.centre_y    = cfg_wdata;
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.cos_first   <= RstCosFirst;
      regs_r.sin_first   <= RstSinFirst;
      regs_r.cos_second  <= RstCosSecond;
      regs_r.sin_second  <= RstSinSecond;
      regs_r.height_gain <= RstGain;
      regs_r.centre_x    <= RstCentreX;
      regs_r.centre_y    <= RstCentreY;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule
